// File: hw/rtl/rgbs_pkg.sv
package rgbs_pkg;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int ROW_W       = 11;
    localparam int OUT_ROW_W   = 10;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int SHARPEN_GAIN = 9;
    localparam int CHAN_MAX    = 255;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CNT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic              opcode;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              end_of_frame;
    } t_out_item;

    // One pipeline step: the line stores and window advance, and maybe emit.
    typedef struct packed {
        logic step;
        logic emit;
        logic border;
        logic last;
    } t_step;

endpackage

// File: hw/rtl/rgbs_ctrl.sv
module rgbs_ctrl #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10,
    parameter int EW        = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  rgbs_pkg::t_in_item            i_in_item,
    input  logic                          i_cfg_we,
    input  logic [rgbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgbs_pkg::CFG_W-1:0]    i_cfg_data,
    output rgbs_pkg::t_step               o_step,
    output logic [rgbs_pkg::PIX_W-1:0]    o_px,
    output logic [AW-1:0]                 o_col
);
    import rgbs_pkg::*;

    logic [CFG_W-1:0]     r_image_width;
    logic [CFG_W-1:0]     r_image_height;
    logic [AW-1:0]        r_in_col,  n_in_col;
    logic [ROW_W-1:0]     r_in_row,  n_in_row;
    logic [AW-1:0]        r_out_col, n_out_col;
    logic [OUT_ROW_W-1:0] r_out_row, n_out_row;

    logic [EW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             frame_in;
    logic             drain;
    logic             col_last;
    logic             out_col_last;
    logic             out_row_last;

    always_comb begin
        eff_w = EW'(r_image_width);
        if (eff_w == '0) begin
            eff_w = EW'(1);
        end else if (eff_w > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end
        eff_h = ROW_W'(r_image_height);
        if (eff_h == '0) begin
            eff_h = ROW_W'(1);
        end else if (eff_h > ROW_W'(HEIGHT_LIMIT)) begin
            eff_h = ROW_W'(HEIGHT_LIMIT);
        end

        frame_in     = r_in_row >= eff_h;
        drain        = i_in_item.opcode == OP_DRAIN;
        col_last     = (EW'(r_in_col) + EW'(1)) >= eff_w;
        out_col_last = (EW'(r_out_col) + EW'(1)) >= eff_w;
        out_row_last = (ROW_W'(r_out_row) + ROW_W'(1)) >= eff_h;

        // A drain before the frame is complete is dropped without effect
        o_step.step   = i_accept && (frame_in || !drain);
        o_step.emit   = (r_in_row >= ROW_W'(2)) ||
                        ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
        o_step.last   = out_row_last && out_col_last;
        o_step.border = (r_out_row == '0) || out_row_last ||
                        (r_out_col == '0) || out_col_last;

        o_px  = frame_in ? '0 : {i_in_item.in_red, i_in_item.in_green, i_in_item.in_blue};
        o_col = r_in_col;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        priority if (i_cfg_we) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (o_step.step) begin
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + AW'(1);
            end
            if (o_step.emit) begin
                if (o_step.last) begin
                    // frame done: restart all positions
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OUT_ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

// File: hw/rtl/rgbs_line_store.sv
module rgbs_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rgbs_pkg::t_step            i_step,
    input  logic [rgbs_pkg::PIX_W-1:0] i_px,
    input  logic [AW-1:0]              i_col,
    output rgbs_pkg::t_step            o_step,
    output logic [rgbs_pkg::PIX_W-1:0] o_upper,
    output logic [rgbs_pkg::PIX_W-1:0] o_middle,
    output logic [rgbs_pkg::PIX_W-1:0] o_px
);
    import rgbs_pkg::*;

    // Each entry holds {upper, middle} for one column
    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_fwd_hit;
    t_step              r_s1_step;
    logic [PIX_W-1:0]   r_s1_px;
    logic [AW-1:0]      r_s1_col;
    logic [2*PIX_W-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_col];
        if (r_s1_step.step) begin
            r_mem[r_s1_col] <= wr_data;
        end
    end

    // Back-to-back transactions on the same column see the pending write
    assign o_upper  = r_fwd_hit ? r_fwd_data[2*PIX_W-1:PIX_W] : r_rd_data[2*PIX_W-1:PIX_W];
    assign o_middle = r_fwd_hit ? r_fwd_data[PIX_W-1:0]       : r_rd_data[PIX_W-1:0];
    assign o_px     = r_s1_px;
    assign o_step   = r_s1_step;
    assign wr_data  = {o_middle, r_s1_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_step <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_s1_step <= i_step;
            r_fwd_hit <= i_step.step && r_s1_step.step && (i_col == r_s1_col);
        end
        r_fwd_data <= wr_data;
        r_s1_px    <= i_px;
        r_s1_col   <= i_col;
    end

endmodule

// File: hw/rtl/rgbs_window_calc.sv
module rgbs_window_calc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rgbs_pkg::t_step            i_step,
    input  logic [rgbs_pkg::PIX_W-1:0] i_upper,
    input  logic [rgbs_pkg::PIX_W-1:0] i_middle,
    input  logic [rgbs_pkg::PIX_W-1:0] i_px,
    output logic                       o_push,
    output rgbs_pkg::t_out_item        o_item
);
    import rgbs_pkg::*;

    logic [PIX_W-1:0] r_win [3][3];
    logic             r_s2_emit;
    logic             r_s2_border;
    logic             r_s2_last;

    logic [CHAN_W-1:0]   res [NUM_CHAN];
    logic [CHAN_W+2:0]   nsum [NUM_CHAN];
    logic [CHAN_W+3:0]   center_x9 [NUM_CHAN];
    logic signed [CHAN_W+4:0] acc [NUM_CHAN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
            r_s2_emit <= 1'b0;
        end else begin
            if (i_step.step) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= i_upper;
                r_win[1][2] <= i_middle;
                r_win[2][2] <= i_px;
            end
            r_s2_emit <= i_step.step && i_step.emit;
        end
        r_s2_border <= i_step.border;
        r_s2_last   <= i_step.last;
    end

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            nsum[k] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (r != 1 || c != 1) begin
                        nsum[k] = nsum[k] + (CHAN_W+3)'(r_win[r][c][CHAN_W*k +: CHAN_W]);
                    end
                end
            end
            center_x9[k] = (CHAN_W+4)'(SHARPEN_GAIN) * (CHAN_W+4)'(r_win[1][1][CHAN_W*k +: CHAN_W]);
            acc[k] = $signed({1'b0, center_x9[k]}) - $signed({2'b00, nsum[k]});
            if (r_s2_border) begin
                res[k] = r_win[1][1][CHAN_W*k +: CHAN_W];
            end else if (acc[k] < 0) begin
                res[k] = '0;
            end else if (acc[k] > (CHAN_W+5)'(CHAN_MAX)) begin
                res[k] = CHAN_W'(CHAN_MAX);
            end else begin
                res[k] = acc[k][CHAN_W-1:0];
            end
        end
    end

    assign o_push              = r_s2_emit;
    assign o_item.out_red      = res[2];
    assign o_item.out_green    = res[1];
    assign o_item.out_blue     = res[0];
    assign o_item.end_of_frame = r_s2_last;

endmodule

// File: hw/rtl/rgbs_out_fifo.sv
module rgbs_out_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  rgbs_pkg::t_out_item             i_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output rgbs_pkg::t_out_item             o_item,
    output logic [rgbs_pkg::FIFO_CNT_W-1:0] o_count
);
    import rgbs_pkg::*;

    t_out_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr_ptr;
    logic [FIFO_AW-1:0]     r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic                   pop;

    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(pop);
        end
    end

endmodule

// File: hw/rtl/rgb_sharpen_3x3_stream.sv
// The transaction that completes a result passes the line store read, the window update
// and the push into a 4-entry output queue before o_out_valid rises.
// Throughput: one transaction per cycle, set by one line store read and write-back per
// cycle; ready drops while queued plus in-flight results fill the 4-entry output queue.
// Reset: positions clear, width/height return to 640/480, window clears;
// line store contents are not cleared and need no clearing pass.
module rgb_sharpen_3x3_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rgbs_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rgbs_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [rgbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgbs_pkg::CFG_W-1:0]     i_cfg_data
);
    import rgbs_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    t_step                  s0_step;
    logic [PIX_W-1:0]       s0_px;
    logic [AW-1:0]          s0_col;
    t_step                  s1_step;
    logic [PIX_W-1:0]       s1_upper;
    logic [PIX_W-1:0]       s1_middle;
    logic [PIX_W-1:0]       s1_px;
    logic                   s2_push;
    t_out_item              s2_item;
    logic [FIFO_CNT_W-1:0]  fifo_count;
    logic [FIFO_CNT_W-1:0]  credit_used;
    logic                   accept;

    // Reserve queue space for every result still in the pipeline
    assign credit_used = fifo_count + FIFO_CNT_W'(s1_step.step && s1_step.emit)
                                    + FIFO_CNT_W'(s2_push);
    assign o_in_ready  = credit_used < FIFO_CNT_W'(FIFO_DEPTH);
    assign accept      = i_in_valid && o_in_ready;

    rgbs_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW),
        .EW        (EW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_step      (s0_step),
        .o_px        (s0_px),
        .o_col       (s0_col)
    );

    rgbs_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s0_step),
        .i_px     (s0_px),
        .i_col    (s0_col),
        .o_step   (s1_step),
        .o_upper  (s1_upper),
        .o_middle (s1_middle),
        .o_px     (s1_px)
    );

    rgbs_window_calc u_window_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_step),
        .i_upper  (s1_upper),
        .i_middle (s1_middle),
        .i_px     (s1_px),
        .o_push   (s2_push),
        .o_item   (s2_item)
    );

    rgbs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s2_push),
        .i_item  (s2_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item),
        .o_count (fifo_count)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        credit_used <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue credit exceeded");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_push && fifo_count == FIFO_CNT_W'(FIFO_DEPTH)) |-> (o_out_valid && i_out_ready))
        else $error("push into full output queue");

    a_push_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s0_step.step && s0_step.emit |=> ##1 s2_push)
        else $error("emitting transaction lost in pipeline");

    a_step_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s0_step.step |-> accept)
        else $error("pipeline step without a transaction");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rgbs_pkg::*;

    localparam int LINE_DEPTH     = 1024;
    localparam int RANDOM_ITEMS   = 720;
    localparam int CALM_ITEMS     = 200;
    localparam int WIDE_EXTRA     = 8;
    localparam int TALL_ITEMS     = 40;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Predictor state
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    logic [PIX_W-1:0] upper_store [0:LINE_DEPTH-1];
    logic [PIX_W-1:0] middle_store [0:LINE_DEPTH-1];
    logic [PIX_W-1:0] nbhd [0:2][0:2];
    int unsigned      in_col, in_row, out_col, out_row;
    t_out_item        expected_pixels [$];

    bit        sender_idles = 1'b0;
    bit        receiver_stalls = 1'b0;
    int        stall_left = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;
    bit        moved;
    t_out_item want_pixel;

    rgb_sharpen_3x3_stream #(
        .MAX_WIDTH(LINE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] value, input int limit);
        if (value < 1) return 1;
        if (value > limit) return limit;
        return int'(value);
    endfunction

    function automatic logic [CHAN_W-1:0] sharpen_channel(input int shift);
        int acc;
        int r, c;
        acc = 0;
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
                if (r == 1 && c == 1)
                    acc += SHARPEN_GAIN * int'((nbhd[r][c] >> shift) & 24'hFF);
                else
                    acc -= int'((nbhd[r][c] >> shift) & 24'hFF);
            end
        end
        if (acc < 0) acc = 0;
        if (acc > CHAN_MAX) acc = CHAN_MAX;
        return acc[CHAN_W-1:0];
    endfunction

    task automatic reset_predictor();
        int i, r, c;
        cfg_width = IMAGE_WIDTH_RESET;
        cfg_height = IMAGE_HEIGHT_RESET;
        for (i = 0; i < LINE_DEPTH; i++) begin
            upper_store[i] = '0;
            middle_store[i] = '0;
        end
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                nbhd[r][c] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic apply_register_write(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_W-1:0] value);
        if (index == REG_IMAGE_WIDTH)
            cfg_width = value;
        else if (index == REG_IMAGE_HEIGHT)
            cfg_height = value;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic predict_sharpened_pixel(input t_in_item item);
        int unsigned w, h, col;
        logic [PIX_W-1:0] px, up, mid, centre;
        bit emit, border, last;
        int r;
        t_out_item res;
        w = clamp_dim(cfg_width, LINE_DEPTH);
        h = clamp_dim(cfg_height, HEIGHT_LIMIT);
        // drain while the frame is still coming in: ignored
        if (in_row < h && item.opcode == OP_DRAIN) return;
        px = (in_row >= h) ? '0 : {item.in_red, item.in_green, item.in_blue};
        col = in_col % LINE_DEPTH;
        up = upper_store[col];
        mid = middle_store[col];
        upper_store[col] = mid;
        middle_store[col] = px;
        for (r = 0; r < 3; r++) begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
        end
        nbhd[0][2] = up;
        nbhd[1][2] = mid;
        nbhd[2][2] = px;
        emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!emit) return;
        border = out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w;
        last = out_row + 1 >= h && out_col + 1 >= w;
        centre = nbhd[1][1];
        if (border) begin
            res.out_red = centre[23:16];
            res.out_green = centre[15:8];
            res.out_blue = centre[7:0];
        end else begin
            res.out_red = sharpen_channel(16);
            res.out_green = sharpen_channel(8);
            res.out_blue = sharpen_channel(0);
        end
        res.end_of_frame = last;
        expected_pixels.push_back(res);
        if (last) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // Monitor: check output, track config, predict, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_pixels.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected output pixel r=%02h g=%02h b=%02h eof=%0b",
                             $time, o_out_item.out_red, o_out_item.out_green,
                             o_out_item.out_blue, o_out_item.end_of_frame);
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    if (o_out_item.out_red !== want_pixel.out_red ||
                        o_out_item.out_green !== want_pixel.out_green ||
                        o_out_item.out_blue !== want_pixel.out_blue ||
                        o_out_item.end_of_frame !== want_pixel.end_of_frame) begin
                        error_count++;
                        $display("%0t: pixel mismatch: expected %07h, got %07h",
                                 $time, want_pixel, o_out_item);
                    end
                end
            end
            if (i_cfg_we) begin
                moved = 1'b1;
                apply_register_write(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                predict_sharpened_pixel(i_in_item);
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("** rgb_sharpen_3x3_stream: FAILED **");
                    $finish;
                end
            end
        end
    end

    // Receiver: stall in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            i_out_ready = 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    function automatic t_in_item pixel_item(input logic [PIX_W-1:0] rgb);
        return {OP_PIXEL, rgb};
    endfunction

    function automatic logic [15:0] rgb_noise();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_in_item drain_item();
        return {OP_DRAIN, 8'($urandom_range(0, 255)), rgb_noise()};
    endfunction

    function automatic logic [CHAN_W-1:0] random_channel();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_item random_pixel();
        t_in_item item;
        item.opcode = OP_PIXEL;
        item.in_red = random_channel();
        item.in_green = random_channel();
        item.in_blue = random_channel();
        return item;
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        @(negedge i_clk);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item = item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, let every expected pixel come out, then let the pipe settle
    task automatic wait_until_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // 4x3 frame: clamp to zero, clamp to full scale, unclamped interior, border pass
    task automatic test_sharpen_clamps();
        logic [PIX_W-1:0] frame [0:11];
        int i;
        frame = '{24'hFF0030, 24'hFF0030, 24'hFF0030, 24'h00FF30,
                  24'hFF0030, 24'h00FF40, 24'hFF0040, 24'h00FF30,
                  24'hFF0030, 24'h00FF30, 24'h00FF30, 24'h00FF30};
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        write_register(REG_IMAGE_WIDTH, 11'd4);
        write_register(REG_IMAGE_HEIGHT, 11'd3);
        send_item(drain_item());
        for (i = 0; i < 12; i++)
            send_item(pixel_item(frame[i]));
        // pixel after the frame is in: its value is dropped
        send_item(pixel_item(24'hFFFFFF));
        repeat (4) send_item(drain_item());
        // frame restarted: this drain does nothing
        send_item(drain_item());
        wait_until_idle();
    endtask

    // single-row frame: first drain yields nothing
    task automatic test_single_row();
        write_register(REG_IMAGE_WIDTH, 11'd2);
        write_register(REG_IMAGE_HEIGHT, 11'd1);
        send_item(pixel_item(24'h000000));
        send_item(pixel_item(24'hFFFFFF));
        repeat (3) send_item(drain_item());
        wait_until_idle();
    endtask

    // width above the line store size clamps to its full depth: results start
    // one full clamped row plus one column in; the frame is left open
    task automatic test_widest_frame();
        int i;
        write_register(REG_IMAGE_WIDTH, 11'd2047);
        write_register(REG_IMAGE_HEIGHT, 11'd3);
        for (i = 0; i < LINE_DEPTH + WIDE_EXTRA; i++)
            send_item(random_pixel());
        wait_until_idle();
    endtask

    // zero width clamps to one column; a height above the row limit clamps to it and the frame is left open
    task automatic test_tallest_frame();
        int i;
        write_register(REG_IMAGE_WIDTH, 11'd0);
        write_register(REG_IMAGE_HEIGHT, 11'd2047);
        for (i = 0; i < TALL_ITEMS; i++)
            send_item(random_pixel());
        wait_until_idle();
    endtask

    function automatic logic [CFG_W-1:0] random_dim();
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd2;
            default: return 11'($urandom_range(3, 12));
        endcase
    endfunction

    task automatic test_random_frames();
        int sent, w_eff, h_eff, total, stop_at, k, mode;
        bit truncated, cut;
        sent = 0;
        truncated = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (RANDOM_ITEMS - sent <= CALM_ITEMS) begin
                sender_idles = 1'b0;
                receiver_stalls = 1'b0;
            end else begin
                sender_idles = $urandom_range(0, 3) != 0;
                receiver_stalls = $urandom_range(0, 3) != 0;
            end
            mode = $urandom_range(truncated ? 1 : 0, 3);
            if (mode != 0) begin
                wait_until_idle();
                if (mode != 2) write_register(REG_IMAGE_WIDTH, random_dim());
                if (mode != 1) write_register(REG_IMAGE_HEIGHT, random_dim());
            end
            w_eff = clamp_dim(cfg_width, LINE_DEPTH);
            h_eff = clamp_dim(cfg_height, HEIGHT_LIMIT);
            total = w_eff * h_eff + w_eff + 1;
            cut = $urandom_range(0, 5) == 0;
            stop_at = cut ? $urandom_range(0, total - 1) : total;
            if ($urandom_range(0, 3) == 0) send_item(drain_item());
            for (k = 0; k < stop_at; k++) begin
                if (k < w_eff * h_eff) begin
                    if ($urandom_range(0, 15) == 0) send_item(drain_item());
                    send_item(random_pixel());
                end else begin
                    // flush the tail; an odd pixel here acts as a drain
                    send_item($urandom_range(0, 3) == 0 ? random_pixel() : drain_item());
                end
                sent++;
            end
            truncated = cut;
        end
    endtask

    initial begin
        reset_predictor();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_sharpen_clamps();
        test_single_row();
        test_widest_frame();
        test_tallest_frame();
        test_random_frames();
        wait_until_idle();
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("** rgb_sharpen_3x3_stream: PASSED **");
        else
            $display("** rgb_sharpen_3x3_stream: FAILED **");
        $finish;
    end

endmodule
